FILE: hdl/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, phase codes, register map and address table of the tactile
// sensor scan sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int PORTS_DEF   = 4;
    localparam int SENSORS_DEF = 9;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_ENABLE_ALL  = 2'd0,
        REG_DISABLE_ALL = 2'd1,
        REG_BARO        = 2'd2
    } reg_idx_t;

    localparam logic [7:0] ENABLE_ALL_RST  = 8'd12;
    localparam logic [7:0] DISABLE_ALL_RST = 8'd13;
    localparam logic [7:0] BARO_RST        = 8'd192;

    localparam logic [7:0] PRESS_SPLIT   = 8'd200;
    localparam logic [8:0] PRESS_LO_BASE = 9'd255;
    localparam logic [8:0] PRESS_HI_BASE = 9'd510;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_DONE  = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_EN_ALL  = 3'd1,
        PH_START   = 3'd2,
        PH_DIS_ALL = 3'd3,
        PH_EN_ONE  = 3'd4,
        PH_SELECT  = 3'd5,
        PH_READ    = 3'd6,
        PH_DIS_ONE = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] enable_all_addr;
        logic [7:0] disable_all_addr;
        logic [7:0] baro_addr;
    } cfg_t;

    typedef struct packed {
        logic       action;
        logic [1:0] port;
        logic       ok;
        logic [7:0] press_byte;
        logic [7:0] temp_hi_byte;
        logic [7:0] temp_lo_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] out_port;
        logic [2:0] next_cmd;
        logic [7:0] dev_addr;
        logic       is_read;
        logic [2:0] byte_count;
        logic       sample_valid;
        logic [5:0] sensor_slot;
        logic [8:0] pressure;
        logic [9:0] temperature;
        logic       scan_done;
    } result_t;

    function automatic logic [7:0] sensor_addr(input logic [3:0] s);
        logic [7:0] a;
        case (s)
            4'd0:    a = 8'h00;
            4'd1:    a = 8'h02;
            4'd2:    a = 8'h04;
            4'd3:    a = 8'h06;
            4'd4:    a = 8'h08;
            4'd5:    a = 8'h10;
            4'd6:    a = 8'h12;
            4'd7:    a = 8'h14;
            4'd8:    a = 8'h16;
            default: a = 8'h00;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/tactile_sensor_scan_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tactile_sensor_scan_sequencer
// Per-port scan sequencer for chains of barometric tactile sensors; one
// result item per input item giving the port's next bus transaction and,
// after a value read, the converted sample.
//
//   Channel  Handshake           Payload
//   in       in_valid/in_stall   action port ok press_byte temp_hi_byte temp_lo_byte
//   out      out_valid/out_stall out_port next_cmd dev_addr is_read byte_count
//                                sample_valid sensor_slot pressure temperature scan_done
//   cfg      APB psel/penable    paddr pwrite pwdata prdata pready
//
// One item per cycle unless out_stall holds; input register, then result register.
// Per-port phase and sensor index live in flip-flops and update as the item
// moves into the result register, so back-to-back items on one port chain.
// Reset puts every port idle at sensor zero and loads the default addresses.
// out_stall holds the result register; in_stall rises only when both
// registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module tactile_sensor_scan_sequencer #(
    parameter int PORTS   = tss_pkg::PORTS_DEF,
    parameter int SENSORS = tss_pkg::SENSORS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tss_pkg::PADDR_W-1:0]  paddr,
    input  logic [tss_pkg::PDATA_W-1:0]  pwdata,
    output logic [tss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic [1:0]                   port,
    input  logic                         ok,
    input  logic [7:0]                   press_byte,
    input  logic [7:0]                   temp_hi_byte,
    input  logic [7:0]                   temp_lo_byte,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   out_port,
    output logic [2:0]                   next_cmd,
    output logic [7:0]                   dev_addr,
    output logic                         is_read,
    output logic [2:0]                   byte_count,
    output logic                         sample_valid,
    output logic [5:0]                   sensor_slot,
    output logic [8:0]                   pressure,
    output logic [9:0]                   temperature,
    output logic                         scan_done
);
    import tss_pkg::*;

    cfg_t     cfg_reg;
    logic     cfg_wr;
    reg_idx_t cfg_idx;

    phase_t     phase_reg [PORTS];
    logic [3:0] sidx_reg  [PORTS];

    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    logic    out_valid_reg;

    logic    advance;
    logic    port_ok;
    phase_t  ph_cur;
    logic [3:0] s_cur;
    phase_t  ph_new;
    logic [3:0] s_new;
    result_t res_next;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_all_addr  <= ENABLE_ALL_RST;
            cfg_reg.disable_all_addr <= DISABLE_ALL_RST;
            cfg_reg.baro_addr        <= BARO_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ENABLE_ALL:  cfg_reg.enable_all_addr  <= pwdata[7:0];
                REG_DISABLE_ALL: cfg_reg.disable_all_addr <= pwdata[7:0];
                REG_BARO:        cfg_reg.baro_addr        <= pwdata[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE_ALL:  prdata = {24'd0, cfg_reg.enable_all_addr};
            REG_DISABLE_ALL: prdata = {24'd0, cfg_reg.disable_all_addr};
            REG_BARO:        prdata = {24'd0, cfg_reg.baro_addr};
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg <= '{action, port, ok, press_byte, temp_hi_byte, temp_lo_byte};
        end
    end

    // current port state
    assign port_ok = {1'b0, in_item_reg.port} < 3'(PORTS);

    always_comb
    begin
        ph_cur = PH_IDLE;
        s_cur  = 4'd0;
        for (int p = 0; p < PORTS; p++)
        begin
            if (in_item_reg.port == 2'(p))
            begin
                ph_cur = phase_reg[p];
                s_cur  = sidx_reg[p];
            end
        end
    end

    tss_step #(
        .SENSORS (SENSORS)
    ) u_step (
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .port_ok (port_ok),
        .ph_cur  (ph_cur),
        .s_cur   (s_cur),
        .ph_new  (ph_new),
        .s_new   (s_new),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                phase_reg[p] <= PH_IDLE;
                sidx_reg[p]  <= 4'd0;
            end
        end
        else if (advance && port_ok)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                if (in_item_reg.port == 2'(p))
                begin
                    phase_reg[p] <= ph_new;
                    sidx_reg[p]  <= s_new;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_port     = res_reg.out_port;
    assign next_cmd     = res_reg.next_cmd;
    assign dev_addr     = res_reg.dev_addr;
    assign is_read      = res_reg.is_read;
    assign byte_count   = res_reg.byte_count;
    assign sample_valid = res_reg.sample_valid;
    assign sensor_slot  = res_reg.sensor_slot;
    assign pressure     = res_reg.pressure;
    assign temperature  = res_reg.temperature;
    assign scan_done    = res_reg.scan_done;

endmodule
`default_nettype wire

FILE: hdl/tss_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_step
// Phase transition and transaction decode for one item on one port.
// ----------------------------------------------------------------------------
module tss_step #(
    parameter int SENSORS = tss_pkg::SENSORS_DEF
) (
    input  tss_pkg::cfg_t    cfg,
    input  tss_pkg::item_t   item,
    input  logic             port_ok,
    input  tss_pkg::phase_t  ph_cur,
    input  logic [3:0]       s_cur,
    output tss_pkg::phase_t  ph_new,
    output logic [3:0]       s_new,
    output tss_pkg::result_t res
);
    import tss_pkg::*;

    logic       last_sensor;
    logic [5:0] slot;
    logic [7:0] s_addr;

    assign last_sensor = ({1'b0, s_cur} + 5'd1) >= 5'(SENSORS);
    assign slot        = 6'(item.port) * 6'(SENSORS) + 6'(s_cur);

    always_comb
    begin
        ph_new = ph_cur;
        s_new  = s_cur;
        s_addr = 8'd0;
        res    = '0;
        res.out_port = item.port;

        if (port_ok)
        begin
            if (item.action == ACT_START)
            begin
                if (ph_cur == PH_IDLE)
                begin
                    ph_new = PH_EN_ALL;
                    s_new  = 4'd0;
                end
            end
            else
            begin
                case (ph_cur)
                    PH_IDLE:
                    begin
                        ph_new = PH_IDLE;
                    end
                    PH_READ:
                    begin
                        res.sample_valid = 1'b1;
                        res.sensor_slot  = slot;
                        res.pressure     = (item.press_byte < PRESS_SPLIT)
                                         ? PRESS_LO_BASE - 9'(item.press_byte)
                                         : PRESS_HI_BASE - 9'(item.press_byte);
                        res.temperature  = {item.temp_hi_byte, item.temp_lo_byte[7:6]};
                        if (item.ok)
                        begin
                            ph_new = PH_DIS_ONE;
                        end
                    end
                    PH_DIS_ONE:
                    begin
                        if (last_sensor)
                        begin
                            ph_new = PH_IDLE;
                            s_new  = 4'd0;
                            res.scan_done = 1'b1;
                        end
                        else if (item.ok)
                        begin
                            ph_new = PH_EN_ONE;
                            s_new  = s_cur + 4'd1;
                        end
                    end
                    default:
                    begin
                        if (item.ok)
                        begin
                            ph_new = phase_t'(ph_cur + 3'd1);
                        end
                    end
                endcase
            end

            s_addr       = sensor_addr(s_new);
            res.next_cmd = ph_new;
            case (ph_new)
                PH_EN_ALL:
                begin
                    res.dev_addr = cfg.enable_all_addr;
                end
                PH_START:
                begin
                    res.dev_addr   = cfg.baro_addr;
                    res.byte_count = 3'd2;
                end
                PH_DIS_ALL:
                begin
                    res.dev_addr   = {1'b0, cfg.disable_all_addr[7:1]};
                    res.is_read    = 1'b1;
                    res.byte_count = 3'd1;
                end
                PH_EN_ONE:
                begin
                    res.dev_addr = s_addr;
                end
                PH_SELECT:
                begin
                    res.dev_addr   = cfg.baro_addr;
                    res.byte_count = 3'd1;
                end
                PH_READ:
                begin
                    res.dev_addr   = {1'b0, cfg.baro_addr[7:1]};
                    res.is_read    = 1'b1;
                    res.byte_count = 3'd4;
                end
                PH_DIS_ONE:
                begin
                    res.dev_addr   = {1'b0, s_addr[7:1]};
                    res.is_read    = 1'b1;
                    res.byte_count = 3'd1;
                end
                default:
                begin
                    res.dev_addr = 8'd0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: dv/tactile_sensor_scan_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tactile_sensor_scan_sequencer_tb
// Self-checking testbench for the tactile sensor scan sequencer. A cycle
// model of the per-port scan phases predicts each result item as its input
// item is accepted. Directed checks cover busy and idle ports, failed
// transactions in every phase and pressure/temperature extremes. Random
// scans then run under several address settings and idling mixes, plus
// one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tactile_sensor_scan_sequencer_tb;

    import tss_pkg::*;

    localparam int NUM_PORTS   = PORTS_DEF;
    localparam int NUM_SENSORS = SENSORS_DEF;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [7:0] SENSOR_BUS_ADDR [0:8] =
        '{8'h00, 8'h02, 8'h04, 8'h06, 8'h08, 8'h10, 8'h12, 8'h14, 8'h16};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic                 action;
    logic [1:0]           port;
    logic                 ok;
    logic [7:0]           press_byte;
    logic [7:0]           temp_hi_byte;
    logic [7:0]           temp_lo_byte;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           out_port;
    logic [2:0]           next_cmd;
    logic [7:0]           dev_addr;
    logic                 is_read;
    logic [2:0]           byte_count;
    logic                 sample_valid;
    logic [5:0]           sensor_slot;
    logic [8:0]           pressure;
    logic [9:0]           temperature;
    logic                 scan_done;

    // scan model state and address registers
    phase_t     port_phase  [0:NUM_PORTS-1];
    logic [3:0] port_sensor [0:NUM_PORTS-1];
    logic [7:0] enable_all_q;
    logic [7:0] disable_all_q;
    logic [7:0] baro_q;

    result_t    pending_results [$];
    result_t    want;
    int         error_count  = 0;
    int         cycle_count  = 0;
    int         sender_idle_pct = 0;
    int         stall_pct    = 0;
    int         hold_request = 0;
    int         hold_cnt     = 0;
    bit         offering     = 1'b0;

    tactile_sensor_scan_sequencer i_dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tactile_sensor_scan_sequencer regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_request != 0)
            begin
                hold_cnt     = hold_request;
                hold_request = 0;
            end
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic result_t scan_step(item_t it);
        result_t    r;
        phase_t     ph;
        logic [3:0] s;
        r  = '0;
        r.out_port = it.port;
        ph = port_phase[it.port];
        s  = port_sensor[it.port];
        if (it.action == ACT_START)
        begin
            if (ph == PH_IDLE)
            begin
                ph = PH_EN_ALL;
                s  = 4'd0;
            end
        end
        else if (ph == PH_READ)
        begin
            r.sample_valid = 1'b1;
            r.sensor_slot  = 6'(it.port * NUM_SENSORS + s);
            r.pressure     = (it.press_byte < PRESS_SPLIT) ?
                             PRESS_LO_BASE - {1'b0, it.press_byte} :
                             PRESS_HI_BASE - {1'b0, it.press_byte};
            r.temperature  = {it.temp_hi_byte, it.temp_lo_byte[7:6]};
            if (it.ok)
                ph = PH_DIS_ONE;
        end
        else if (ph == PH_DIS_ONE)
        begin
            if (int'(s) + 1 >= NUM_SENSORS)
            begin
                ph = PH_IDLE;
                s  = 4'd0;
                r.scan_done = 1'b1;
            end
            else if (it.ok)
            begin
                ph = PH_EN_ONE;
                s  = s + 4'd1;
            end
        end
        else if (ph != PH_IDLE)
        begin
            if (it.ok)
                ph = phase_t'(ph + 3'd1);
        end
        port_phase[it.port]  = ph;
        port_sensor[it.port] = s;

        r.next_cmd = ph;
        case (ph)
            PH_EN_ALL:  begin r.dev_addr = enable_all_q;       r.byte_count = 3'd0; end
            PH_START:   begin r.dev_addr = baro_q;             r.byte_count = 3'd2; end
            PH_DIS_ALL: begin r.dev_addr = disable_all_q >> 1; r.is_read = 1'b1;
                              r.byte_count = 3'd1; end
            PH_EN_ONE:  begin r.dev_addr = SENSOR_BUS_ADDR[s]; r.byte_count = 3'd0; end
            PH_SELECT:  begin r.dev_addr = baro_q;             r.byte_count = 3'd1; end
            PH_READ:    begin r.dev_addr = baro_q >> 1;        r.is_read = 1'b1;
                              r.byte_count = 3'd4; end
            PH_DIS_ONE: begin r.dev_addr = SENSOR_BUS_ADDR[s] >> 1; r.is_read = 1'b1;
                              r.byte_count = 3'd1; end
            default:    r.dev_addr = 8'd0;
        endcase
        return r;
    endfunction

    function automatic item_t make_item(action_t act, logic [1:0] p, logic good,
                                        logic [7:0] pb, logic [7:0] th, logic [7:0] tl);
        item_t it;
        it.action       = act;
        it.port         = p;
        it.ok           = good;
        it.press_byte   = pb;
        it.temp_hi_byte = th;
        it.temp_lo_byte = tl;
        return it;
    endfunction

    // well-formed: start an idle port, complete a busy one; noise: anything
    function automatic item_t random_scan_item(bit noise);
        logic [1:0] p;
        item_t      it;
        p  = 2'($urandom_range(NUM_PORTS - 1));
        it = make_item(port_phase[p] == PH_IDLE ? ACT_START : ACT_DONE, p,
                       $urandom_range(99) < 90, 8'($urandom), 8'($urandom), 8'($urandom));
        if (noise)
        begin
            it.action = 1'($urandom_range(1));
            it.ok     = 1'($urandom_range(1));
        end
        return it;
    endfunction

    // in_stall only moves at rising edges; sample it mid-cycle
    task automatic send_item(item_t it);
        in_valid     <= 1'b1;
        offering      = 1'b1;
        action       <= it.action;
        port         <= it.port;
        ok           <= it.ok;
        press_byte   <= it.press_byte;
        temp_hi_byte <= it.temp_hi_byte;
        temp_lo_byte <= it.temp_lo_byte;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        pending_results.push_back(scan_step(it));
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            offering  = 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering  = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic cfg_write(reg_idx_t idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ENABLE_ALL:  enable_all_q  = value;
            REG_DISABLE_ALL: disable_all_q = value;
            default:         baro_q        = value;
        endcase
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== PDATA_W'(value))
        begin
            error_count++;
            $display("%0t: reg %s expected %0d actual %0d", $time, idx.name(), value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_addresses(logic [7:0] en_all, logic [7:0] dis_all, logic [7:0] baro);
        wait_drain();
        cfg_write(REG_ENABLE_ALL, en_all);
        cfg_write(REG_DISABLE_ALL, dis_all);
        cfg_write(REG_BARO, baro);
    endtask

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val !== act_val)
        begin
            error_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
        end
    endtask

    // results are taken on the following rising edge; sample mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result for port %0d with no item pending", $time, out_port);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_port", want.out_port, out_port);
                check_field("next_cmd", want.next_cmd, next_cmd);
                check_field("dev_addr", want.dev_addr, dev_addr);
                check_field("is_read", want.is_read, is_read);
                check_field("byte_count", want.byte_count, byte_count);
                check_field("sample_valid", want.sample_valid, sample_valid);
                check_field("sensor_slot", want.sensor_slot, sensor_slot);
                check_field("pressure", want.pressure, pressure);
                check_field("temperature", want.temperature, temperature);
                check_field("scan_done", want.scan_done, scan_done);
            end
        end
    end

    task automatic test_idle_and_busy_ports();
        send_item(make_item(ACT_DONE, 2'd1, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(ACT_START, 2'd1, 1'b0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(ACT_START, 2'd1, 1'b1, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_phase_walk();
        send_item(make_item(ACT_START, 2'd3, 1'b1, 8'h00, 8'h00, 8'h00));
        // each transaction before the read fails once, then succeeds
        for (int i = 0; i < 5; i++)
        begin
            send_item(make_item(ACT_DONE, 2'd3, 1'b0, 8'h00, 8'h00, 8'h00));
            send_item(make_item(ACT_DONE, 2'd3, 1'b1, 8'h00, 8'h00, 8'h00));
        end
        // failed reads still give samples; pressure split around 200
        send_item(make_item(ACT_DONE, 2'd3, 1'b0, 8'd199, 8'h00, 8'h00));
        send_item(make_item(ACT_DONE, 2'd3, 1'b0, 8'd200, 8'hFF, 8'hFF));
        send_item(make_item(ACT_DONE, 2'd3, 1'b0, 8'd0, 8'hAA, 8'h40));
        send_item(make_item(ACT_DONE, 2'd3, 1'b1, 8'd255, 8'h55, 8'hC0));
        // failed disable retries the same sensor
        send_item(make_item(ACT_DONE, 2'd3, 1'b0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(ACT_DONE, 2'd3, 1'b1, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic run_random_scans(int count, int idle_pct, int stall_mix);
        sender_idle_pct = idle_pct;
        stall_pct       = stall_mix;
        for (int i = 0; i < count; i++)
            send_item(random_scan_item($urandom_range(99) < 15));
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_request    = 300;
        for (int i = 0; i < 40; i++)
            send_item(random_scan_item(1'b0));
        wait_drain();
    endtask

    task automatic test_settings_and_idling();
        set_addresses(8'hFF, 8'hFF, 8'hFF);
        run_random_scans(300, 0, 0);
        set_addresses(8'h00, 8'h00, 8'h00);
        run_random_scans(300, 81, 0);
        set_addresses(8'($urandom), 8'($urandom), 8'($urandom));
        run_random_scans(300, 0, 81);
        set_addresses(8'($urandom) | 8'h01, 8'($urandom) | 8'h01, 8'($urandom));
        run_random_scans(300, 19, 19);
        wait_drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        action        = 1'b0;
        port          = 2'd0;
        ok            = 1'b0;
        press_byte    = 8'd0;
        temp_hi_byte  = 8'd0;
        temp_lo_byte  = 8'd0;
        enable_all_q  = ENABLE_ALL_RST;
        disable_all_q = DISABLE_ALL_RST;
        baro_q        = BARO_RST;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            port_phase[p]  = PH_IDLE;
            port_sensor[p] = 4'd0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_busy_ports();
        test_phase_walk();
        wait_drain();
        test_backpressure();
        test_settings_and_idling();

        wait_drain();
        if (error_count == 0)
            $display("tactile_sensor_scan_sequencer regression: pass");
        else
            $display("tactile_sensor_scan_sequencer regression: fail");
        $finish;
    end

endmodule
